/* sv/svf_pkg.sv */
// shared types, byte constants and packet builder for the servo command framer
`timescale 1ns / 1ps

package svf_pkg;

    // command mode codes
    localparam logic [2:0] MODE_MOVE       = 3'd0;
    localparam logic [2:0] MODE_TORQUE     = 3'd1;
    localparam logic [2:0] MODE_RD_STATUS  = 3'd2;
    localparam logic [2:0] MODE_RD_RANGE   = 3'd3;
    localparam logic [2:0] MODE_RD_TORQUE  = 3'd4;

    // fixed packet bytes
    localparam logic [7:0] HDR_FIRST    = 8'hFA;
    localparam logic [7:0] HDR_SECOND   = 8'hAF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] BYTE_ONE     = 8'h01;
    localparam logic [7:0] ADDR_MOVE    = 8'h1E;
    localparam logic [7:0] ADDR_TORQUE  = 8'h24;
    localparam logic [7:0] LEN_MOVE     = 8'h04;
    localparam logic [7:0] FLAG_STATUS  = 8'h09;
    localparam logic [7:0] FLAG_READ    = 8'h0F;
    localparam logic [7:0] ADDR_RANGE   = 8'h2A;
    localparam logic [7:0] LEN_RANGE    = 8'h0A;

    // bytes ahead of the checksum, longest packet
    localparam int          MAX_BYTES = 11;
    localparam int          SREG_W    = MAX_BYTES * 8;
    localparam logic [3:0]  NB_MOVE   = 4'd11;
    localparam logic [3:0]  NB_TORQUE = 4'd8;
    localparam logic [3:0]  NB_READ   = 4'd7;
    // first byte index covered by the checksum
    localparam logic [3:0]  SUM_START = 4'd2;

    // control from the sequencer to the byte shifter
    typedef struct packed {
        logic load;
        logic shift;
    } t_shift_ctrl;

    // control from the sequencer to the checksum accumulator
    typedef struct packed {
        logic clear;
        logic accum;
    } t_xor_ctrl;

    // packet bytes ahead of the checksum, first byte in the low bits
    function automatic logic [SREG_W-1:0] f_packet_bytes(
        input logic [2:0]  mode,
        input logic [7:0]  servo_id,
        input logic [15:0] position,
        input logic [15:0] move_time,
        input logic [7:0]  torque_value
    );
        logic [SREG_W-1:0] v;
        v = '0;
        unique case (mode)
            MODE_MOVE: begin
                v[87:0] = {move_time[15:8], move_time[7:0], position[15:8], position[7:0],
                           BYTE_ONE, LEN_MOVE, ADDR_MOVE, BYTE_ZERO,
                           servo_id, HDR_SECOND, HDR_FIRST};
            end
            MODE_TORQUE: begin
                v[63:0] = {torque_value, BYTE_ONE, BYTE_ONE, ADDR_TORQUE, BYTE_ZERO,
                           servo_id, HDR_SECOND, HDR_FIRST};
            end
            MODE_RD_STATUS: begin
                v[55:0] = {BYTE_ONE, BYTE_ZERO, BYTE_ZERO, FLAG_STATUS,
                           servo_id, HDR_SECOND, HDR_FIRST};
            end
            MODE_RD_RANGE: begin
                v[55:0] = {BYTE_ZERO, LEN_RANGE, ADDR_RANGE, FLAG_READ,
                           servo_id, HDR_SECOND, HDR_FIRST};
            end
            default: begin
                v[55:0] = {BYTE_ZERO, BYTE_ONE, ADDR_TORQUE, FLAG_READ,
                           servo_id, HDR_SECOND, HDR_FIRST};
            end
        endcase
        return v;
    endfunction

    // number of bytes ahead of the checksum
    function automatic logic [3:0] f_packet_len(input logic [2:0] mode);
        logic [3:0] n;
        unique case (mode)
            MODE_MOVE:   n = NB_MOVE;
            MODE_TORQUE: n = NB_TORQUE;
            default:     n = NB_READ;
        endcase
        return n;
    endfunction

endpackage

/* sv/svf_if.sv */
// handshake channels for commands and packet bytes
`timescale 1ns / 1ps

interface svf_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [7:0]         servo_id;
    logic signed [15:0] position;
    logic [15:0]        move_time;
    logic [7:0]         torque_value;

    modport source (output valid, mode, servo_id, position, move_time, torque_value,
                    input ready);
    modport sink   (input valid, mode, servo_id, position, move_time, torque_value,
                    output ready);
endinterface

interface svf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, tx_byte, last_byte, input ready);
    modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

/* sv/svf_shift.sv */
// byte-wide shift register holding the packet bytes still to be sent
`timescale 1ns / 1ps

module svf_shift (
    input  logic                         i_clk,
    input  svf_pkg::t_shift_ctrl         i_ctrl,
    input  logic [svf_pkg::SREG_W-1:0]   i_load_bytes,
    output logic [7:0]                   o_head
);
    import svf_pkg::*;

    logic [SREG_W-1:0] r_sreg;
    logic [SREG_W-1:0] n_sreg;

    // load a whole packet or drop the byte just sent
    always_comb begin
        n_sreg = r_sreg;
        if (i_ctrl.load) begin
            n_sreg = i_load_bytes;
        end else if (i_ctrl.shift) begin
            n_sreg = {8'h00, r_sreg[SREG_W-1:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sreg <= n_sreg;
    end

    assign o_head = r_sreg[7:0];
endmodule

/* sv/svf_xor_acc.sv */
// running xor of the bytes covered by the checksum
`timescale 1ns / 1ps

module svf_xor_acc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  svf_pkg::t_xor_ctrl i_ctrl,
    input  logic [7:0]         i_byte,
    output logic [7:0]         o_sum
);
    import svf_pkg::*;

    logic [7:0] r_sum;
    logic [7:0] n_sum;

    // clear at packet start, fold in one byte per beat
    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.clear) begin
            n_sum = 8'h00;
        end else if (i_ctrl.accum) begin
            n_sum = r_sum ^ i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= 8'h00;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;
endmodule

/* sv/servo_command_packet_framer.sv */
// top level: servo command in, serial short packet out one byte per beat
`timescale 1ns / 1ps

// One command beat in, one packet out, one byte per output beat with last_byte
// on the closing checksum. The packet bytes load into a byte-wide shift
// register and leave at one byte per cycle unless the output stalls, while
// a running xor builds the checksum. A packet is 12 bytes for move, 9 for
// torque set and 8 for the three reads, and no new command is taken until
// its checksum is in the output register; output stalls hold the bytes back.
// The command is taken in the idle state and the first byte moves from the
// shifter head to the output register in the send state. The next command is
// taken in the cycle after the checksum moves to the output register, even
// while that byte waits. Mode codes 5 to 7 are taken and produce nothing.
module servo_command_packet_framer (
    input  logic    i_clk,
    input  logic    i_rst_n,
    svf_cmd_if.sink   i_cmd,
    svf_byte_if.source o_tx
);
    import svf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state      r_state;
    logic [3:0]  r_byte_cnt;
    logic [3:0]  r_len;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    t_shift_ctrl w_shift_ctrl;
    t_xor_ctrl   w_xor_ctrl;
    logic [7:0]  w_head;
    logic [7:0]  w_sum;
    logic        w_accept;
    logic        w_mode_ok;
    logic        w_advance;
    logic        w_at_sum;

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_mode_ok   = (i_cmd.mode <= MODE_RD_TORQUE);
    assign w_advance   = (r_state == ST_SEND) && (!r_out_valid || o_tx.ready);
    assign w_at_sum    = (r_byte_cnt == r_len);

    // shifter and checksum control
    always_comb begin
        w_shift_ctrl.load  = w_accept && w_mode_ok;
        w_shift_ctrl.shift = w_advance && !w_at_sum;
        w_xor_ctrl.clear   = w_accept && w_mode_ok;
        w_xor_ctrl.accum   = w_advance && !w_at_sum && (r_byte_cnt >= SUM_START);
    end

    svf_shift u_shift (
        .i_clk        (i_clk),
        .i_ctrl       (w_shift_ctrl),
        .i_load_bytes (f_packet_bytes(i_cmd.mode, i_cmd.servo_id, i_cmd.position,
                                      i_cmd.move_time, i_cmd.torque_value)),
        .o_head       (w_head)
    );

    svf_xor_acc u_xor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_xor_ctrl),
        .i_byte  (w_head),
        .o_sum   (w_sum)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_byte_cnt  <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            // output beat valid: set on each new byte, cleared once taken
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_tx.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && w_mode_ok) begin
                        r_state    <= ST_SEND;
                        r_byte_cnt <= 4'd0;
                        r_len      <= f_packet_len(i_cmd.mode);
                    end
                end
                ST_SEND: begin
                    if (w_advance) begin
                        if (w_at_sum) begin
                            r_out_byte <= w_sum;
                            r_out_last <= 1'b1;
                            r_byte_cnt <= 4'd0;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_out_byte <= w_head;
                            r_out_last <= 1'b0;
                            r_byte_cnt <= r_byte_cnt + 4'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_tx.valid     = r_out_valid;
    assign o_tx.tx_byte   = r_out_byte;
    assign o_tx.last_byte = r_out_last;
endmodule

/* tb/testbench.sv */
// self-checking testbench for the servo command packet framer
`timescale 1ns / 1ps

module testbench;
    import svf_pkg::*;

    // highest mode code the field can carry, codes above read torque are ignored
    localparam logic [2:0] MODE_LAST_CODE = 3'd7;
    localparam int         RANDOM_ITEMS   = 100;
    localparam int         QUIET_ITEMS    = 30;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         DRAIN_CYCLES   = 20;

    // one expected packet byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_tx_beat;

    // predicts packet bytes per accepted command and checks them in order
    class packet_scoreboard;
        t_tx_beat pending[$];
        int       errors;
        int       ignored;
        int       bytes_checked;
        int       mode_count[5];

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_command(input logic [2:0] mode, input logic [7:0] id,
                                   input logic [15:0] pos, input logic [15:0] tim,
                                   input logic [7:0] trq);
            logic [7:0] body[$];
            logic [7:0] flag, addr, len, cnt;
            logic [7:0] sum;
            if (mode > MODE_RD_TORQUE) begin
                ignored++;
                return;
            end
            mode_count[mode]++;
            // flag, address, length and count per mode
            case (mode)
                MODE_MOVE: begin
                    flag = BYTE_ZERO; addr = ADDR_MOVE; len = LEN_MOVE; cnt = BYTE_ONE;
                end
                MODE_TORQUE: begin
                    flag = BYTE_ZERO; addr = ADDR_TORQUE; len = BYTE_ONE; cnt = BYTE_ONE;
                end
                MODE_RD_STATUS: begin
                    flag = FLAG_STATUS; addr = BYTE_ZERO; len = BYTE_ZERO; cnt = BYTE_ONE;
                end
                MODE_RD_RANGE: begin
                    flag = FLAG_READ; addr = ADDR_RANGE; len = LEN_RANGE; cnt = BYTE_ZERO;
                end
                default: begin
                    flag = FLAG_READ; addr = ADDR_TORQUE; len = BYTE_ONE; cnt = BYTE_ZERO;
                end
            endcase
            body.push_back(id);
            body.push_back(flag);
            body.push_back(addr);
            body.push_back(len);
            body.push_back(cnt);
            // data bytes, little-endian
            if (mode == MODE_MOVE) begin
                body.push_back(pos[7:0]);
                body.push_back(pos[15:8]);
                body.push_back(tim[7:0]);
                body.push_back(tim[15:8]);
            end else if (mode == MODE_TORQUE) begin
                body.push_back(trq);
            end
            pending.push_back(t_tx_beat'{HDR_FIRST, 1'b0});
            pending.push_back(t_tx_beat'{HDR_SECOND, 1'b0});
            sum = 8'h00;
            foreach (body[i]) begin
                sum = sum ^ body[i];
                pending.push_back(t_tx_beat'{body[i], 1'b0});
            end
            pending.push_back(t_tx_beat'{sum, 1'b1});
        endfunction

        task check_byte(input logic [7:0] data, input logic last);
            t_tx_beat want;
            bytes_checked++;
            if (pending.size() == 0) begin
                report($sformatf("byte %02h last %0b with nothing expected", data, last));
                return;
            end
            want = pending.pop_front();
            if (data !== want.data)
                report($sformatf("tx_byte %02h, expected %02h", data, want.data));
            if (last !== want.last)
                report($sformatf("last_byte %0b, expected %0b (byte %02h)",
                                 last, want.last, want.data));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   tail_quiet;
    int   cycles;

    svf_cmd_if  cmd_ch ();
    svf_byte_if tx_ch ();

    packet_scoreboard sb = new();

    servo_command_packet_framer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_tx    (tx_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycles, sb.pending.size());
            $display("FAIL servo_command_packet_framer");
            $finish;
        end
    end

    // observe accepted beats on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(cmd_ch.mode, cmd_ch.servo_id, cmd_ch.position,
                                cmd_ch.move_time, cmd_ch.torque_value);
            if (tx_ch.valid && tx_ch.ready)
                sb.check_byte(tx_ch.tx_byte, tx_ch.last_byte);
        end
    end

    // byte receiver with random stall bursts
    initial begin
        tx_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!tail_quiet && $urandom_range(0, 4) == 0) begin
                tx_ch.ready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            tx_ch.ready = 1'b1;
        end
    end

    // present one command and hold it until taken, returns at a falling edge
    task automatic send_command(input logic [2:0] mode, input logic [7:0] id,
                                input logic [15:0] pos, input logic [15:0] tim,
                                input logic [7:0] trq);
        cmd_ch.mode         = mode;
        cmd_ch.servo_id     = id;
        cmd_ch.position     = pos;
        cmd_ch.move_time    = tim;
        cmd_ch.torque_value = trq;
        cmd_ch.valid        = 1'b1;
        do @(posedge i_clk); while (!cmd_ch.ready);
        @(negedge i_clk);
        if (!tail_quiet && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
    endtask

    // random command, mostly valid modes with some unused codes mixed in
    task automatic send_random(output bit counted);
        logic [2:0] mode;
        if ($urandom_range(0, 9) == 0)
            mode = 3'($urandom_range(MODE_RD_TORQUE + 1, MODE_LAST_CODE));
        else
            mode = 3'($urandom_range(MODE_MOVE, MODE_RD_TORQUE));
        counted = (mode <= MODE_RD_TORQUE);
        send_command(mode, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // wait at a falling edge until every predicted byte has come out
    task automatic wait_drained();
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // stimulus and end of run
    initial begin
        int  sent;
        bit  counted;
        cmd_ch.valid        = 1'b0;
        cmd_ch.mode         = MODE_MOVE;
        cmd_ch.servo_id     = '0;
        cmd_ch.position     = '0;
        cmd_ch.move_time    = '0;
        cmd_ch.torque_value = '0;
        i_rst_n             = 1'b0;
        tail_quiet          = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: field extremes for each mode, junk in unused fields
        send_command(MODE_MOVE, 8'h00, 16'h8000, 16'h0000, 8'hFF);
        send_command(MODE_MOVE, 8'hFF, 16'h7FFF, 16'hFFFF, 8'h00);
        send_command(MODE_MOVE, 8'h5A, 16'hFFFF, 16'h1234, 8'h3C);
        send_command(MODE_MOVE, 8'hA5, 16'h0000, 16'h8001, 8'hC3);
        send_command(MODE_TORQUE, 8'h00, 16'hFFFF, 16'hFFFF, 8'h00);
        send_command(MODE_TORQUE, 8'hFF, 16'h0000, 16'h0000, 8'hFF);
        send_command(MODE_TORQUE, 8'h01, 16'h5555, 16'hAAAA, 8'h01);
        send_command(MODE_TORQUE, 8'h80, 16'hAAAA, 16'h5555, 8'h02);
        send_command(MODE_RD_STATUS, 8'h00, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_command(MODE_RD_STATUS, 8'hFF, 16'h0000, 16'h0000, 8'h00);
        send_command(MODE_RD_RANGE, 8'h00, 16'h1234, 16'h5678, 8'h9A);
        send_command(MODE_RD_RANGE, 8'hFF, 16'h0000, 16'h0000, 8'h00);
        send_command(MODE_RD_TORQUE, 8'h00, 16'hFFFF, 16'h0000, 8'hFF);
        send_command(MODE_RD_TORQUE, 8'hFF, 16'h0000, 16'hFFFF, 8'h00);
        // unused codes produce nothing and leave the framer ready
        for (int m = MODE_RD_TORQUE + 1; m <= MODE_LAST_CODE; m++) begin
            send_command(m[2:0], 8'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom));
            send_command(MODE_MOVE, 8'($urandom), 16'($urandom), 16'($urandom),
                         8'($urandom));
        end

        // random commands, with one full drain part way through
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == RANDOM_ITEMS / 2) begin
                cmd_ch.valid = 1'b0;
                wait_drained();
            end
            if (sent == RANDOM_ITEMS - QUIET_ITEMS)
                tail_quiet = 1'b1;
            send_random(counted);
            if (counted)
                sent++;
        end
        cmd_ch.valid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("packets by mode: move %0d, torque %0d, status %0d, range %0d, rd torque %0d",
                 sb.mode_count[MODE_MOVE], sb.mode_count[MODE_TORQUE],
                 sb.mode_count[MODE_RD_STATUS], sb.mode_count[MODE_RD_RANGE],
                 sb.mode_count[MODE_RD_TORQUE]);
        $display("%0d unused mode codes dropped, %0d bytes compared, %0d mismatches",
                 sb.ignored, sb.bytes_checked, sb.errors);
        if (sb.errors == 0)
            $display("PASS servo_command_packet_framer");
        else
            $display("FAIL servo_command_packet_framer");
        $finish;
    end

endmodule

/* files.f */
sv/svf_pkg.sv
sv/svf_if.sv
sv/svf_shift.sv
sv/svf_xor_acc.sv
sv/servo_command_packet_framer.sv
tb/testbench.sv
